// ----- sv/spfe_pkg.sv -----
// Shared types and constants for the spectral peak frequency estimator.
// Used by spfe_div, spfe_ctrl, spfe_dp and the top level; no dependencies.
package spfe_pkg;

    // Default array sizes for the top-level parameters.
    localparam int DefBins = 16;
    localparam int DefAxes = 3;

    // Fixed field widths.
    localparam int AxisW  = 2;
    localparam int MagW   = 24;
    localparam int FreqW  = 16;
    localparam int PeakW  = 5;
    localparam int StartW = 5;
    localparam int WidthW = 12;
    localparam int AlphaW = 16;
    localparam int QuotW  = 9;

    // Configuration port.
    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 24;

    localparam logic [CfgIdxW-1:0] CFG_START_BIN    = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_MIN_FREQ     = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_BIN_WIDTH    = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_SMOOTH_ALPHA = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_REF_ENERGY_X = 3'd4;
    localparam logic [CfgIdxW-1:0] CFG_REF_ENERGY_Y = 3'd5;
    localparam logic [CfgIdxW-1:0] CFG_REF_ENERGY_Z = 3'd6;

    // Register reset values.
    localparam logic [StartW-1:0] START_BIN_RST    = 5'd3;
    localparam logic [FreqW-1:0]  MIN_FREQ_RST     = 16'd1280;
    localparam logic [WidthW-1:0] BIN_WIDTH_RST    = 12'd500;
    localparam logic [AlphaW-1:0] SMOOTH_ALPHA_RST = 16'd15663;
    localparam logic [MagW-1:0]   REF_ENERGY_RST   = 24'd0;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;       // an input beat is accepted this cycle
        logic div_start;  // last bin accepted: snapshot peak, start divider
        logic freq;       // form the interpolated frequency product
        logic clamp;      // threshold, clamp and filter difference
        logic filt;       // form the smoothing step product
        logic load;       // update the filter and load the result beat
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last_bin;   // the beat at the input closes a spectrum
        logic div_busy;   // divider still iterating
    } t_sts;

endpackage

// ----- sv/spfe_div.sv -----
// Iterative restoring divider giving floor(256*num/den) for num <= den.
// Depends on spfe_pkg for widths.
module spfe_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [spfe_pkg::MagW-1:0]   i_num,
    input  logic [spfe_pkg::MagW:0]     i_den,
    output logic                        o_busy,
    output logic [spfe_pkg::QuotW-1:0]  o_quot
);

    localparam int RemW = spfe_pkg::MagW + 2;

    logic [3:0]                   r_cnt;
    logic                         r_first;
    logic [RemW-1:0]              r_rem;
    logic [spfe_pkg::MagW:0]      r_den;
    logic [spfe_pkg::QuotW-1:0]   r_quot;

    logic [RemW-1:0] rem_shift;
    logic            fits;

    // The first step compares the numerator itself; later ones shift in a zero.
    always_comb begin
        rem_shift = r_first ? r_rem : {r_rem[RemW-2:0], 1'b0};
        fits      = rem_shift >= {1'b0, r_den};
    end

    // One quotient bit per cycle, most significant first.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= 4'd0;
            r_first <= 1'b0;
        end else if (i_start) begin
            r_cnt   <= 4'(spfe_pkg::QuotW);
            r_first <= 1'b1;
        end else if (r_cnt != 4'd0) begin
            r_cnt   <= r_cnt - 4'd1;
            r_first <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= RemW'(i_num);
            r_den  <= i_den;
            r_quot <= '0;
        end else if (r_cnt != 4'd0) begin
            r_rem  <= fits ? (rem_shift - {1'b0, r_den}) : rem_shift;
            r_quot <= {r_quot[spfe_pkg::QuotW-2:0], fits};
        end
    end

    assign o_busy = r_cnt != 4'd0;
    assign o_quot = r_quot;

endmodule

// ----- sv/spfe_ctrl.sv -----
// Sequencing state machine: bin tracking, then the end-of-spectrum arithmetic.
// Depends on spfe_pkg for the command and status structs.
module spfe_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    input  spfe_pkg::t_sts    i_sts,
    output spfe_pkg::t_cmd    o_cmd
);

    typedef enum logic [2:0] {
        ST_TRACK,
        ST_DIV,
        ST_FREQ,
        ST_CLAMP,
        ST_FILT,
        ST_LOAD
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   load_ok;

    // Commands follow from the state; the output slot frees when its beat leaves.
    always_comb begin
        load_ok         = !r_out_valid || !i_out_stall;
        o_cmd.take      = (r_state == ST_TRACK) && i_in_valid;
        o_cmd.div_start = (r_state == ST_TRACK) && i_in_valid && i_sts.last_bin;
        o_cmd.freq      = r_state == ST_FREQ;
        o_cmd.clamp     = r_state == ST_CLAMP;
        o_cmd.filt      = r_state == ST_FILT;
        o_cmd.load      = (r_state == ST_LOAD) && load_ok;
    end

    // State and the result valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_TRACK;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                ST_TRACK: begin
                    if (o_cmd.div_start) r_state <= ST_DIV;
                end
                ST_DIV: begin
                    if (!i_sts.div_busy) r_state <= ST_FREQ;
                end
                ST_FREQ:  r_state <= ST_CLAMP;
                ST_CLAMP: r_state <= ST_FILT;
                ST_FILT:  r_state <= ST_LOAD;
                ST_LOAD: begin
                    if (load_ok) r_state <= ST_TRACK;
                end
                default: r_state <= ST_TRACK;
            endcase
            if (o_cmd.load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_stall  = r_state != ST_TRACK;
    assign o_out_valid = r_out_valid;

    // The divider is idle whenever a new division is started.
    a_div_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_start |-> !i_sts.div_busy)
        else $error("divider started while busy");

    // Closing a spectrum always enters the division wait.
    a_div_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_start |=> (r_state == ST_DIV && i_sts.div_busy))
        else $error("division did not start after the last bin");

    // A waiting result is never overwritten by the next one.
    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LOAD && r_out_valid && i_out_stall) |=> (r_state == ST_LOAD))
        else $error("result overwritten while stalled");

    // Loading a result always raises the output valid.
    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (o_out_valid && r_state == ST_TRACK))
        else $error("loaded result not presented");

endmodule

// ----- sv/spfe_dp.sv -----
// Datapath: configuration registers, peak tracker, divider, multipliers, filter.
// Depends on spfe_pkg and instantiates spfe_div.
module spfe_dp #(
    parameter int BINS = spfe_pkg::DefBins,
    parameter int AXES = spfe_pkg::DefAxes
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  spfe_pkg::t_cmd                  i_cmd,
    output spfe_pkg::t_sts                  o_sts,
    input  logic                            i_cfg_we,
    input  logic [spfe_pkg::CfgIdxW-1:0]    i_cfg_index,
    input  logic [spfe_pkg::CfgDataW-1:0]   i_cfg_data,
    input  logic [spfe_pkg::AxisW-1:0]      i_axis,
    input  logic [spfe_pkg::MagW-1:0]       i_bin_magnitude,
    output logic [spfe_pkg::AxisW-1:0]      o_out_axis,
    output logic [spfe_pkg::PeakW-1:0]      o_peak_bin,
    output logic [spfe_pkg::MagW-1:0]       o_peak_energy,
    output logic [spfe_pkg::FreqW-1:0]      o_center_freq,
    output logic [spfe_pkg::FreqW-1:0]      o_smoothed_freq
);

    localparam int CW   = $clog2(BINS + 1);
    localparam int SW   = (CW > spfe_pkg::StartW) ? CW : spfe_pkg::StartW;
    localparam int AW   = (AXES > 1) ? $clog2(AXES) : 1;
    localparam int OpW  = CW + 8;
    localparam int PrW  = OpW + spfe_pkg::WidthW;
    localparam int MagW = spfe_pkg::MagW;
    localparam int FW   = spfe_pkg::FreqW;
    localparam logic [CW-1:0] LastBin = CW'(BINS);

    // Configuration registers.
    logic [spfe_pkg::StartW-1:0] r_start_bin;
    logic [FW-1:0]               r_min_freq;
    logic [spfe_pkg::WidthW-1:0] r_bin_width;
    logic [spfe_pkg::AlphaW-1:0] r_smooth_alpha;
    logic [MagW-1:0]             r_ref_x, r_ref_y, r_ref_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_bin    <= spfe_pkg::START_BIN_RST;
            r_min_freq     <= spfe_pkg::MIN_FREQ_RST;
            r_bin_width    <= spfe_pkg::BIN_WIDTH_RST;
            r_smooth_alpha <= spfe_pkg::SMOOTH_ALPHA_RST;
            r_ref_x        <= spfe_pkg::REF_ENERGY_RST;
            r_ref_y        <= spfe_pkg::REF_ENERGY_RST;
            r_ref_z        <= spfe_pkg::REF_ENERGY_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                spfe_pkg::CFG_START_BIN:    r_start_bin    <= i_cfg_data[spfe_pkg::StartW-1:0];
                spfe_pkg::CFG_MIN_FREQ:     r_min_freq     <= i_cfg_data[FW-1:0];
                spfe_pkg::CFG_BIN_WIDTH:    r_bin_width    <= i_cfg_data[spfe_pkg::WidthW-1:0];
                spfe_pkg::CFG_SMOOTH_ALPHA: r_smooth_alpha <= i_cfg_data[spfe_pkg::AlphaW-1:0];
                spfe_pkg::CFG_REF_ENERGY_X: r_ref_x        <= i_cfg_data[MagW-1:0];
                spfe_pkg::CFG_REF_ENERGY_Y: r_ref_y        <= i_cfg_data[MagW-1:0];
                spfe_pkg::CFG_REF_ENERGY_Z: r_ref_z        <= i_cfg_data[MagW-1:0];
                default: ;
            endcase
        end
    end

    // Effective start bin: zero acts as one, beyond the last bin acts as the last.
    logic [SW-1:0] start_ext;
    logic [CW-1:0] eff_start;

    always_comb begin
        start_ext = SW'(r_start_bin);
        if (start_ext == '0) begin
            eff_start = CW'(1);
        end else if (start_ext > SW'(BINS)) begin
            eff_start = LastBin;
        end else begin
            eff_start = start_ext[CW-1:0];
        end
    end

    // Bin tracker state.
    logic [CW-1:0]   r_count, n_count;
    logic [MagW-1:0] r_prev, n_prev;
    logic [MagW-1:0] r_peak, n_peak;
    logic [MagW-1:0] r_left, n_left;
    logic [MagW-1:0] r_right, n_right;
    logic [CW-1:0]   r_idx, n_idx;
    logic            r_pending, n_pending;
    logic            axis_ok;
    logic            last_bin;

    always_comb begin
        axis_ok   = {2'b00, i_axis} < 4'(AXES);
        last_bin  = (r_count == LastBin) && axis_ok;
        n_prev    = i_bin_magnitude;
        n_peak    = r_peak;
        n_left    = r_left;
        n_idx     = r_idx;
        n_right   = r_pending ? i_bin_magnitude : r_right;
        n_pending = 1'b0;
        if (r_count >= eff_start &&
            (r_count == eff_start || i_bin_magnitude > r_peak)) begin
            n_peak    = i_bin_magnitude;
            n_idx     = r_count;
            n_left    = r_prev;
            n_right   = '0;
            n_pending = 1'b1;
        end
        n_count = r_count + CW'(1);
    end

    // Advance on every in-range bin; the last bin clears for the next spectrum.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_cmd.take && last_bin)) begin
            r_count   <= '0;
            r_prev    <= '0;
            r_peak    <= '0;
            r_left    <= '0;
            r_right   <= '0;
            r_idx     <= '0;
            r_pending <= 1'b0;
        end else if (i_cmd.take && axis_ok) begin
            r_count   <= n_count;
            r_prev    <= n_prev;
            r_peak    <= n_peak;
            r_left    <= n_left;
            r_right   <= n_right;
            r_idx     <= n_idx;
            r_pending <= n_pending;
        end
    end

    // Snapshot of the finished spectrum and the division operands.
    logic [spfe_pkg::AxisW-1:0] r_ax;
    logic [CW-1:0]              r_k;
    logic [MagW-1:0]            r_y2;
    logic                       r_use_left;
    logic                       r_den_zero;
    logic                       use_left;
    logic [MagW-1:0]            div_num;
    logic [MagW:0]              div_den;
    logic [spfe_pkg::QuotW-1:0] quot;
    logic                       div_busy;

    always_comb begin
        use_left = n_left > n_right;
        if (use_left) begin
            div_num = n_peak;
            div_den = {1'b0, n_left} + {1'b0, n_peak};
        end else begin
            div_num = n_right;
            div_den = {1'b0, n_peak} + {1'b0, n_right};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_ax       <= i_axis;
            r_k        <= n_idx;
            r_y2       <= n_peak;
            r_use_left <= use_left;
            r_den_zero <= div_den == '0;
        end
    end

    spfe_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_busy  (div_busy),
        .o_quot  (quot)
    );

    // Interpolated position in 1/256 bin, times the bin width.
    logic [MagW-1:0] thr;
    logic [OpW-1:0]  pos;
    logic [CW-1:0]   base;
    logic [PrW-1:0]  r_prod;
    logic            r_above;

    always_comb begin
        case (r_ax)
            2'd0:    thr = r_ref_x;
            2'd1:    thr = r_ref_y;
            default: thr = r_ref_z;
        endcase
        base = r_use_left ? (r_k - CW'(1)) : r_k;
        if (r_k >= LastBin) begin
            pos = {r_k, 8'd0};
        end else begin
            pos = {base, 8'd0} + OpW'(r_den_zero ? '0 : quot);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.freq) begin
            r_prod  <= pos * PrW'(r_bin_width);
            r_above <= r_y2 > thr;
        end
    end

    // Per-axis filter state.
    logic [FW-1:0] r_filt [AXES];
    logic [3:0]    ax_ext;
    logic [AW-1:0] ax_sel;
    logic [FW-1:0] filt_cur;

    always_comb begin
        ax_ext   = {2'b00, r_ax};
        ax_sel   = ax_ext[AW-1:0];
        filt_cur = r_filt[ax_sel];
    end

    // Saturate, choose against the threshold, clamp, and take the difference.
    logic [31:0]   freq32;
    logic [FW-1:0] freq_sat;
    logic [FW-1:0] center;
    logic [FW-1:0] r_center;
    logic [FW-1:0] r_absdiff;
    logic          r_neg;

    always_comb begin
        freq32   = 32'(r_prod >> 8);
        freq_sat = (freq32[31:FW] != '0) ? '1 : freq32[FW-1:0];
        center   = r_above ? freq_sat : r_min_freq;
        if (center < r_min_freq) center = r_min_freq;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clamp) begin
            r_center  <= center;
            r_neg     <= center < filt_cur;
            r_absdiff <= (center < filt_cur) ? (filt_cur - center) : (center - filt_cur);
        end
    end

    // Smoothing step: |diff| * alpha in Q0.16.
    logic [31:0]   step_full;
    logic [FW-1:0] r_step;
    logic [FW-1:0] filt_new;

    assign step_full = 32'(r_absdiff) * 32'(r_smooth_alpha);

    always_ff @(posedge i_clk) begin
        if (i_cmd.filt) r_step <= step_full[31:16];
    end

    assign filt_new = r_neg ? (filt_cur - r_step) : (filt_cur + r_step);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < AXES; a++) r_filt[a] <= spfe_pkg::MIN_FREQ_RST;
        end else if (i_cmd.load) begin
            r_filt[ax_sel] <= filt_new;
        end
    end

    // Result beat registers.
    logic [8:0] k_ext;
    assign k_ext = 9'(r_k);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            o_out_axis      <= r_ax;
            o_peak_bin      <= k_ext[spfe_pkg::PeakW-1:0];
            o_peak_energy   <= r_y2;
            o_center_freq   <= r_center;
            o_smoothed_freq <= filt_new;
        end
    end

    assign o_sts.last_bin = last_bin;
    assign o_sts.div_busy = div_busy;

endmodule

// ----- sv/spectral_peak_frequency_estimator.sv -----
// Top level of the spectral peak frequency estimator.
// Depends on spfe_pkg, spfe_ctrl and spfe_dp.
//
// Bins 0..BINS of one spectrum arrive as input beats, one per cycle while the
// input is not stalled; beats whose axis is not below AXES are taken and
// ignored. After the last bin the input stalls while the end-of-spectrum
// arithmetic runs: the restoring divider of the Jain fraction (nine quotient
// bits, then a check that it has finished), the bin-width product, the
// threshold and clamp, the smoothing product, and a final step that loads
// the result beat. The result is held in an output register, so bins of the
// next spectrum are taken while it waits; only the loading of the following
// result waits for it to leave, and the input stays stalled for as long as
// that load waits.
module spectral_peak_frequency_estimator #(
    parameter int BINS = spfe_pkg::DefBins,
    parameter int AXES = spfe_pkg::DefAxes
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [spfe_pkg::CfgIdxW-1:0]    i_cfg_index,
    input  logic [spfe_pkg::CfgDataW-1:0]   i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [spfe_pkg::AxisW-1:0]      i_axis,
    input  logic [spfe_pkg::MagW-1:0]       i_bin_magnitude,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [spfe_pkg::AxisW-1:0]      o_out_axis,
    output logic [spfe_pkg::PeakW-1:0]      o_peak_bin,
    output logic [spfe_pkg::MagW-1:0]       o_peak_energy,
    output logic [spfe_pkg::FreqW-1:0]      o_center_freq,
    output logic [spfe_pkg::FreqW-1:0]      o_smoothed_freq
);

    spfe_pkg::t_cmd cmd;
    spfe_pkg::t_sts sts;

    // Sequencer.
    spfe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Tracker and arithmetic.
    spfe_dp #(
        .BINS (BINS),
        .AXES (AXES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_axis          (i_axis),
        .i_bin_magnitude (i_bin_magnitude),
        .o_out_axis      (o_out_axis),
        .o_peak_bin      (o_peak_bin),
        .o_peak_energy   (o_peak_energy),
        .o_center_freq   (o_center_freq),
        .o_smoothed_freq (o_smoothed_freq)
    );

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for spectral_peak_frequency_estimator: streams spectra in, predicts
// each peak result in a scoreboard class and compares every result beat field by field.
// Depends on spfe_pkg and the spectral_peak_frequency_estimator RTL.
module testbench;

    localparam int AxisW    = spfe_pkg::AxisW;
    localparam int MagW     = spfe_pkg::MagW;
    localparam int FreqW    = spfe_pkg::FreqW;
    localparam int PeakW    = spfe_pkg::PeakW;
    localparam int StartW   = spfe_pkg::StartW;
    localparam int WidthW   = spfe_pkg::WidthW;
    localparam int AlphaW   = spfe_pkg::AlphaW;
    localparam int CfgIdxW  = spfe_pkg::CfgIdxW;
    localparam int CfgDataW = spfe_pkg::CfgDataW;

    localparam int NumBins     = spfe_pkg::DefBins;
    localparam int NumAxes     = spfe_pkg::DefAxes;
    localparam int IgnoredAxis = 3;
    localparam int QuietLimit  = 2000;
    localparam int DrainCycles = 24;
    localparam int ReportMax   = 10;

    typedef struct packed {
        logic [AxisW-1:0] axis;
        logic [PeakW-1:0] peak_bin;
        logic [MagW-1:0]  energy;
        logic [FreqW-1:0] center;
        logic [FreqW-1:0] smoothed;
    } t_peak_beat;

    // Tracks the peak search and the per-axis filters, and holds the peaks still to come.
    class peak_checker;
        logic [StartW-1:0] start_bin;
        logic [FreqW-1:0]  min_freq;
        logic [WidthW-1:0] bin_width;
        logic [AlphaW-1:0] alpha;
        logic [MagW-1:0]   peak_thr[3];

        int unsigned       bin_count;
        int unsigned       peak_idx;
        logic [MagW-1:0]   prev_mag, peak_mag, left_mag, right_mag;
        bit                right_pending;
        logic [FreqW-1:0]  filt_freq[NumAxes];

        t_peak_beat        expected_peaks[$];
        int unsigned       mismatches;

        function new();
            start_bin = spfe_pkg::START_BIN_RST;
            min_freq  = spfe_pkg::MIN_FREQ_RST;
            bin_width = spfe_pkg::BIN_WIDTH_RST;
            alpha     = spfe_pkg::SMOOTH_ALPHA_RST;
            foreach (peak_thr[i]) peak_thr[i] = spfe_pkg::REF_ENERGY_RST;
            foreach (filt_freq[i]) filt_freq[i] = spfe_pkg::MIN_FREQ_RST;
            mismatches = 0;
            clear_tracker();
        endfunction

        function void clear_tracker();
            bin_count     = 0;
            peak_idx      = 0;
            prev_mag      = '0;
            peak_mag      = '0;
            left_mag      = '0;
            right_mag     = '0;
            right_pending = 1'b0;
        endfunction

        function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
            case (idx)
                spfe_pkg::CFG_START_BIN:    start_bin   = data[StartW-1:0];
                spfe_pkg::CFG_MIN_FREQ:     min_freq    = data[FreqW-1:0];
                spfe_pkg::CFG_BIN_WIDTH:    bin_width   = data[WidthW-1:0];
                spfe_pkg::CFG_SMOOTH_ALPHA: alpha       = data[AlphaW-1:0];
                spfe_pkg::CFG_REF_ENERGY_X: peak_thr[0] = data[MagW-1:0];
                spfe_pkg::CFG_REF_ENERGY_Y: peak_thr[1] = data[MagW-1:0];
                spfe_pkg::CFG_REF_ENERGY_Z: peak_thr[2] = data[MagW-1:0];
                default: ;
            endcase
        endfunction

        // Jain interpolation around the tracked peak, saturated to 16 bits.
        function int unsigned interp_freq();
            longint unsigned k, base, frac, num, den, f;
            k    = peak_idx;
            frac = 0;
            if (k >= NumBins) begin
                f = k * bin_width;
            end else begin
                if (left_mag > right_mag) begin
                    num  = peak_mag;
                    den  = 64'(left_mag) + 64'(peak_mag);
                    base = k - 1;
                end else begin
                    num  = right_mag;
                    den  = 64'(peak_mag) + 64'(right_mag);
                    base = k;
                end
                if (den != 0) frac = (num << 8) / den;
                f = (((base << 8) + frac) * bin_width) >> 8;
            end
            return (f > 65535) ? 65535 : int'(f);
        endfunction

        // Accepted input beat: advance the tracker and queue a peak on the last bin.
        function void take_bin(logic [AxisW-1:0] ax, logic [MagW-1:0] mag);
            int unsigned     first;
            int unsigned     center;
            longint          diff;
            longint unsigned delta;
            t_peak_beat      r;
            if (ax >= NumAxes) return;
            if (right_pending) begin
                right_mag     = mag;
                right_pending = 1'b0;
            end
            first = (start_bin == 0) ? 1 : ((start_bin > NumBins) ? NumBins : start_bin);
            if (bin_count >= first && (bin_count == first || mag > peak_mag)) begin
                peak_mag      = mag;
                peak_idx      = bin_count;
                left_mag      = prev_mag;
                right_mag     = '0;
                right_pending = 1'b1;
            end
            prev_mag = mag;
            if (bin_count < NumBins) begin
                bin_count++;
                return;
            end

            if (peak_mag > peak_thr[ax]) center = interp_freq();
            else center = min_freq;
            if (center < min_freq) center = min_freq;

            // First-order low-pass toward the new center frequency.
            diff = longint'(center) - longint'(filt_freq[ax]);
            if (diff >= 0) begin
                delta = (longint'(diff) * longint'(alpha)) >>> 16;
                filt_freq[ax] = filt_freq[ax] + FreqW'(delta);
            end else begin
                delta = (longint'(-diff) * longint'(alpha)) >>> 16;
                filt_freq[ax] = filt_freq[ax] - FreqW'(delta);
            end

            r.axis     = ax;
            r.peak_bin = PeakW'(peak_idx);
            r.energy   = peak_mag;
            r.center   = FreqW'(center);
            r.smoothed = filt_freq[ax];
            expected_peaks.push_back(r);
            clear_tracker();
        endfunction

        function void field_check(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                mismatches++;
                if (mismatches <= ReportMax)
                    $display("mismatch in %s: expected %0d, got %0d", name, want, got);
            end
        endfunction

        // Accepted result beat: compare with the oldest expected peak.
        function void check_peak(t_peak_beat got);
            t_peak_beat want;
            if (expected_peaks.size() == 0) begin
                mismatches++;
                if (mismatches <= ReportMax)
                    $display("result beat with no peak expected: axis %0d bin %0d freq %0d",
                             got.axis, got.peak_bin, got.center);
                return;
            end
            want = expected_peaks.pop_front();
            field_check("out_axis", want.axis, got.axis);
            field_check("peak_bin", want.peak_bin, got.peak_bin);
            field_check("peak_energy", want.energy, got.energy);
            field_check("center_freq", want.center, got.center);
            field_check("smoothed_freq", want.smoothed, got.smoothed);
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n         = 1'b0;
    logic                i_cfg_we        = 1'b0;
    logic [CfgIdxW-1:0]  i_cfg_index     = '0;
    logic [CfgDataW-1:0] i_cfg_data      = '0;
    logic                i_in_valid      = 1'b0;
    logic                o_in_stall;
    logic [AxisW-1:0]    i_axis          = '0;
    logic [MagW-1:0]     i_bin_magnitude = '0;
    logic                o_out_valid;
    logic                i_out_stall     = 1'b0;
    logic [AxisW-1:0]    o_out_axis;
    logic [PeakW-1:0]    o_peak_bin;
    logic [MagW-1:0]     o_peak_energy;
    logic [FreqW-1:0]    o_center_freq;
    logic [FreqW-1:0]    o_smoothed_freq;

    int unsigned         snd_idle_pct  = 0;
    int unsigned         rcv_stall_pct = 0;
    int unsigned         quiet_cycles  = 0;
    peak_checker         sb;

    spectral_peak_frequency_estimator #(
        .BINS(NumBins),
        .AXES(NumAxes)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_axis         (i_axis),
        .i_bin_magnitude(i_bin_magnitude),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_axis     (o_out_axis),
        .o_peak_bin     (o_peak_bin),
        .o_peak_energy  (o_peak_energy),
        .o_center_freq  (o_center_freq),
        .o_smoothed_freq(o_smoothed_freq)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Random output stall, redrawn every cycle.
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < rcv_stall_pct);
    end

    // Result monitor.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_peak({o_out_axis, o_peak_bin, o_peak_energy, o_center_freq,
                           o_smoothed_freq});
    end

    // Watchdog on cycles without any accepted beat or register write.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || i_cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QuietLimit) begin
            $display("testbench NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Send one bin beat, with random idle cycles ahead of it.
    task automatic send_bin(input logic [AxisW-1:0] ax, input logic [MagW-1:0] mag);
        while ($urandom_range(99) < snd_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_axis          <= ax;
        i_bin_magnitude <= mag;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.take_bin(ax, mag);
    endtask

    // Hold the input until every expected peak has left, then let the block settle.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (sb.expected_peaks.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    // Write enable is left high; the caller lowers it after the last write.
    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        sb.set_reg(idx, data);
    endtask

    function automatic logic [CfgDataW-1:0] rand_threshold();
        case ($urandom_range(3))
            0:       return '0;
            1:       return 24'hFFFFFF;
            2:       return CfgDataW'($urandom_range(24'h0FFFFF));
            default: return CfgDataW'($urandom);
        endcase
    endfunction

    // Register settings per segment: the first few pin the extremes.
    task automatic load_settings(input int seg);
        logic [CfgDataW-1:0] v_start, v_min, v_width, v_alpha, v_rx, v_ry, v_rz;
        case (seg)
            1: begin
                v_start = 0;  v_min = 0;      v_width = 4095; v_alpha = 65535;
                v_rx = 0;     v_ry = 0;       v_rz = 0;
            end
            2: begin
                v_start = 16; v_min = 65535;  v_width = 1;    v_alpha = 0;
                v_rx = 24'hFFFFFF; v_ry = 24'hFFFFFF; v_rz = 24'hFFFFFF;
            end
            3: begin
                // Start bin beyond the spectrum and a zero bin width.
                v_start = 31; v_min = 0;      v_width = 0;    v_alpha = 1;
                v_rx = 0;     v_ry = rand_threshold(); v_rz = 24'hFFFFFF;
            end
            default: begin
                v_start = ($urandom_range(9) == 0) ? CfgDataW'($urandom_range(31))
                                                   : CfgDataW'($urandom_range(1, 16));
                v_min   = ($urandom_range(4) == 0) ? CfgDataW'($urandom_range(65535))
                                                   : CfgDataW'($urandom_range(3000));
                v_width = CfgDataW'($urandom_range(1, 4095));
                v_alpha = CfgDataW'($urandom_range(65535));
                v_rx    = rand_threshold();
                v_ry    = rand_threshold();
                v_rz    = rand_threshold();
            end
        endcase
        write_reg(spfe_pkg::CFG_START_BIN, v_start);
        write_reg(spfe_pkg::CFG_MIN_FREQ, v_min);
        write_reg(spfe_pkg::CFG_BIN_WIDTH, v_width);
        write_reg(spfe_pkg::CFG_SMOOTH_ALPHA, v_alpha);
        write_reg(spfe_pkg::CFG_REF_ENERGY_X, v_rx);
        write_reg(spfe_pkg::CFG_REF_ENERGY_Y, v_ry);
        write_reg(spfe_pkg::CFG_REF_ENERGY_Z, v_rz);
        i_cfg_we <= 1'b0;
    endtask

    // One whole spectrum of random content, shaped to reach the interesting peaks.
    task automatic send_spectrum();
        logic [AxisW-1:0] axes[NumBins+1];
        logic [MagW-1:0]  mags[NumBins+1];
        logic [AxisW-1:0] ax0;
        logic [MagW-1:0]  top;
        int               pick;
        int               k;
        ax0  = AxisW'($urandom_range(NumAxes - 1));
        pick = $urandom_range(99);
        foreach (axes[i]) axes[i] = ax0;
        if ($urandom_range(99) < 15)
            foreach (axes[i]) axes[i] = AxisW'($urandom_range(NumAxes - 1));

        if (pick < 40) begin
            // Single peak over low noise, neighbours anywhere from zero up to its height.
            k   = $urandom_range(NumBins);
            top = MagW'($urandom_range(24'hFFFFFF, 24'h001000));
            foreach (mags[i]) mags[i] = MagW'($urandom_range(24'h000FFF));
            mags[k] = top;
            if (k > 0) mags[k-1] = MagW'($urandom_range(top));
            if (k < NumBins) mags[k+1] = MagW'($urandom_range(top));
        end else if (pick < 55) begin
            foreach (mags[i]) mags[i] = MagW'($urandom);
        end else if (pick < 65) begin
            // Tiny values: many ties and zero sums.
            foreach (mags[i]) mags[i] = MagW'($urandom_range(3));
        end else if (pick < 72) begin
            foreach (mags[i]) mags[i] = '0;
        end else if (pick < 82) begin
            // Peak on the last bin.
            foreach (mags[i]) mags[i] = MagW'($urandom_range(24'h7FFFFF));
            mags[NumBins] = MagW'($urandom_range(24'hFFFFFF, 24'h800000));
        end else if (pick < 92) begin
            // Peak exactly at the threshold of the closing axis.
            top = sb.peak_thr[axes[NumBins]];
            foreach (mags[i]) mags[i] = MagW'($urandom_range(top));
            mags[$urandom_range(1, NumBins)] = top;
        end else begin
            top = MagW'($urandom);
            foreach (mags[i]) mags[i] = top;
        end

        for (int i = 0; i <= NumBins; i++) begin
            if ($urandom_range(99) < 5) send_bin(IgnoredAxis, MagW'($urandom));
            send_bin(axes[i], mags[i]);
        end
    endtask

    // Main sequence.
    initial begin
        sb = new();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed spectrum under reset settings: full-scale bin before the start bin,
        // an ignored beat, a tie after the peak, and an axis change on the last bin.
        send_bin(1, 24'hFFFFFF);
        send_bin(1, 0);
        send_bin(1, 5);
        send_bin(1, 100);
        send_bin(IgnoredAxis, 24'hFFFFFF);
        send_bin(1, 24'h800000);
        send_bin(0, 24'h800000);
        for (int i = 6; i < NumBins; i++) send_bin(1, MagW'(i));
        send_bin(2, 24'h000001);
        send_bin(IgnoredAxis, 24'h000000);

        // Random segments, each with its own settings and idling pattern.
        for (int seg = 0; seg < 8; seg++) begin
            if (seg > 0) begin
                wait_drained();
                load_settings(seg);
            end
            case (seg % 4)
                0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
                1: begin snd_idle_pct = 75; rcv_stall_pct = 0;  end
                2: begin snd_idle_pct = 0;  rcv_stall_pct = 75; end
                default: begin snd_idle_pct = 16; rcv_stall_pct = 16; end
            endcase
            for (int n = 0; n < 3; n++) begin
                send_spectrum();
                if ($urandom_range(11) == 0) wait_drained();
            end
        end

        wait_drained();
        if (sb.mismatches == 0 && sb.expected_peaks.size() == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end
endmodule

// ----- filelist.f -----
sv/spfe_pkg.sv
sv/spfe_div.sv
sv/spfe_ctrl.sv
sv/spfe_dp.sv
sv/spectral_peak_frequency_estimator.sv
tb/testbench.sv
